FILE: hdl/cbm_pkg.sv
`timescale 1ns / 1ps

package cbm_pkg;

    // item kinds carried on the input tuser
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_MEASURE = 2'd0;
    localparam logic [OP_W-1:0] OP_XRUN    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    // field widths
    localparam int DATA_W  = 32;
    localparam int LOAD_W  = 20;
    localparam int HEAD_W  = 14;
    localparam int SCALE_W = 14;
    localparam int DIVD_W  = DATA_W + SCALE_W;

    // stream word widths
    localparam int IN_TDATA_W  = 2 * DATA_W;
    localparam int OUT_FIELD_W = 9 * DATA_W + LOAD_W + HEAD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // fixed-point scaling of the load figure
    localparam logic [SCALE_W-1:0] FULL_SCALE = 14'd10000;
    localparam logic [LOAD_W-1:0]  LOAD_SAT   = 20'd1000000;

    localparam logic [DATA_W-1:0] DEADLINE_RST = 32'd1;
    localparam int COUNTER_BITS_DEF = 32;

    // request to the serial divider
    typedef struct packed {
        logic              go;
        logic [DIVD_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } cbm_div_req_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } cbm_div_stat_t;

endpackage

FILE: hdl/cbm_div.sv
`timescale 1ns / 1ps

// Serial restoring divider for the load figure: quotient saturated at LOAD_SAT.
// One shared 33-bit subtractor does the overflow check and every quotient bit.
module cbm_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cbm_pkg::cbm_div_req_t           req,
    output cbm_pkg::cbm_div_stat_t          stat,
    output logic [cbm_pkg::LOAD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(cbm_pkg::LOAD_W);
    localparam int W     = cbm_pkg::DATA_W;

    localparam logic [1:0] DV_IDLE  = 2'd0;
    localparam logic [1:0] DV_CHECK = 2'd1;
    localparam logic [1:0] DV_RUN   = 2'd2;
    localparam logic [1:0] DV_DONE  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [W-1:0]                rem_reg, rem_next;
    logic [cbm_pkg::LOAD_W-1:0]  lq_reg, lq_next;
    logic [W-1:0]                divisor_reg, divisor_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        sat_reg, sat_next;

    logic [W:0]   op_a;
    logic [W+1:0] diff;
    logic         ge;

    // shared subtractor: high part against divisor, then one bit a cycle
    always_comb
    begin
        if (state_reg == DV_CHECK)
        begin
            op_a = {1'b0, rem_reg};
        end
        else
        begin
            op_a = {rem_reg, lq_reg[cbm_pkg::LOAD_W-1]};
        end
        diff = {1'b0, op_a} - {2'b00, divisor_reg};
        ge   = ~diff[W+1];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        rem_next     = rem_reg;
        lq_next      = lq_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        sat_next     = sat_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (req.go)
                begin
                    rem_next     = W'(req.dividend[cbm_pkg::DIVD_W-1:cbm_pkg::LOAD_W]);
                    lq_next      = req.dividend[cbm_pkg::LOAD_W-1:0];
                    divisor_next = req.divisor;
                    sat_next     = 1'b0;
                    state_next   = DV_CHECK;
                end
            end
            DV_CHECK:
            begin
                // quotient would need more than LOAD_W bits (or divisor is zero)
                if (ge)
                begin
                    sat_next   = 1'b1;
                    state_next = DV_DONE;
                end
                else
                begin
                    cnt_next   = CNT_W'(cbm_pkg::LOAD_W - 1);
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                rem_next = ge ? diff[W-1:0] : op_a[W-1:0];
                lq_next  = {lq_reg[cbm_pkg::LOAD_W-2:0], ge};
                if (cnt_reg == '0)
                begin
                    state_next = DV_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        lq_reg      <= lq_next;
        divisor_reg <= divisor_next;
        cnt_reg     <= cnt_next;
        sat_reg     <= sat_next;
    end

    assign stat.busy = (state_reg != DV_IDLE);
    assign stat.done = (state_reg == DV_DONE);
    assign quotient  = (sat_reg || (lq_reg > cbm_pkg::LOAD_SAT)) ? cbm_pkg::LOAD_SAT : lq_reg;

endmodule

FILE: hdl/cycle_budget_monitor.sv
`timescale 1ns / 1ps
// A measure word steps through S_MUL, S_GO and S_DIV to S_DONE; the serial divider gives
// one quotient bit a cycle over 20 bits, and skips those steps when the load saturates.
// Xrun, clear and unused words go from acceptance straight to S_DONE.
// Throughput: one word at a time; the next is taken once the result sits in the output
// register. Reset (rst_n, async, low) clears statistics, sets deadline to 1, on_time to 1.

module cycle_budget_monitor
#(
    parameter int COUNTER_BITS = cbm_pkg::COUNTER_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration: cycle budget per block
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbm_pkg::DATA_W-1:0]         cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: start_count[31:0], end_count[63:32]
    input  logic [cbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [cbm_pkg::OP_W-1:0]           s_axis_tuser,
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: elapsed_cycles, peak_cycles, least_cycles, average_cycles, total_cycles,
    // measure_count, overrun_count, xrun_count, slack (32 each), load_hundredths (20),
    // headroom_hundredths (14), on_time (1), zero pad to whole bytes
    output logic [cbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int W  = cbm_pkg::DATA_W;
    localparam int EW = (COUNTER_BITS >= W) ? W : COUNTER_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_GO   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [W-1:0]                     deadline_reg, deadline_next;
    logic [W-1:0]                     peak_reg, peak_next;
    logic [W-1:0]                     least_reg, least_next;
    logic [W-1:0]                     avg_reg, avg_next;
    logic [W-1:0]                     total_reg, total_next;
    logic [W-1:0]                     count_reg, count_next;
    logic [W-1:0]                     overrun_reg, overrun_next;
    logic [W-1:0]                     xrun_reg, xrun_next;
    logic [W-1:0]                     elapsed_reg, elapsed_next;
    logic [cbm_pkg::LOAD_W-1:0]       load_reg, load_next;
    logic                             on_time_reg, on_time_next;
    logic [cbm_pkg::DIVD_W-1:0]       product_reg, product_next;
    logic                             out_valid_reg, out_valid_next;
    logic [cbm_pkg::OUT_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic                             in_take;
    logic                             out_load;
    logic [cbm_pkg::OP_W-1:0]         op;
    logic [EW-1:0]                    e_narrow;
    logic [W-1:0]                     e;
    logic [W-1:0]                     d;
    logic [W-1:0]                     slack_val;
    logic [cbm_pkg::HEAD_W-1:0]       headroom;

    cbm_pkg::cbm_div_req_t            div_req;
    cbm_pkg::cbm_div_stat_t           div_stat;
    logic [cbm_pkg::LOAD_W-1:0]       div_q;

    // a pending budget write goes first, so a word never meets a budget change
    assign s_axis_tready = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready     = (state_reg == S_IDLE);
    assign in_take       = s_axis_tvalid & s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign op            = s_axis_tuser;

    // elapsed time, wrapping at the counter width
    always_comb
    begin
        e_narrow = s_axis_tdata[W +: EW] - s_axis_tdata[0 +: EW];
        e        = W'(e_narrow);
        d        = e - avg_reg;
    end

    // serial divider for the load figure
    assign div_req.go       = (state_reg == S_GO);
    assign div_req.dividend = product_reg;
    assign div_req.divisor  = deadline_reg;

    cbm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // sequencer and statistics update
    always_comb
    begin
        state_next    = state_reg;
        deadline_next = deadline_reg;
        peak_next     = peak_reg;
        least_next    = least_reg;
        avg_next      = avg_reg;
        total_next    = total_reg;
        count_next    = count_reg;
        overrun_next  = overrun_reg;
        xrun_next     = xrun_reg;
        elapsed_next  = elapsed_reg;
        load_next     = load_reg;
        on_time_next  = on_time_reg;
        product_next  = product_reg;

        if (cfg_valid && cfg_ready)
        begin
            deadline_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_DONE;
                    unique case (op)
                        cbm_pkg::OP_MEASURE:
                        begin
                            total_next   = total_reg + e;
                            count_next   = count_reg + W'(1);
                            peak_next    = (e > peak_reg) ? e : peak_reg;
                            least_next   = (e < least_reg) ? e : least_reg;
                            avg_next     = avg_reg + W'($signed(d) >>> 4);
                            elapsed_next = e;
                            if (e > deadline_reg)
                            begin
                                overrun_next = overrun_reg + W'(1);
                                xrun_next    = xrun_reg + W'(1);
                                on_time_next = 1'b0;
                            end
                            else
                            begin
                                on_time_next = 1'b1;
                            end
                            state_next = S_MUL;
                        end
                        cbm_pkg::OP_XRUN:
                        begin
                            xrun_next    = xrun_reg + W'(1);
                            on_time_next = 1'b0;
                        end
                        cbm_pkg::OP_CLEAR:
                        begin
                            peak_next    = '0;
                            least_next   = '1;
                            avg_next     = '0;
                            total_next   = '0;
                            count_next   = '0;
                            overrun_next = '0;
                            xrun_next    = '0;
                            on_time_next = 1'b1;
                        end
                        default:
                        begin
                            // unused code: state unchanged, result still given
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                product_next = cbm_pkg::DIVD_W'(elapsed_reg)
                             * cbm_pkg::DIVD_W'(cbm_pkg::FULL_SCALE);
                state_next   = S_GO;
            end
            S_GO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    load_next  = div_q;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result word
    always_comb
    begin
        slack_val = deadline_reg - elapsed_reg;
        if (load_reg >= cbm_pkg::LOAD_W'(cbm_pkg::FULL_SCALE))
        begin
            headroom = '0;
        end
        else
        begin
            headroom = cbm_pkg::FULL_SCALE - load_reg[cbm_pkg::HEAD_W-1:0];
        end
        out_data_next = {{cbm_pkg::OUT_PAD_W{1'b0}}, on_time_reg, headroom, load_reg,
                         slack_val, xrun_reg, overrun_reg, count_reg, total_reg,
                         avg_reg, least_reg, peak_reg, elapsed_reg};
        out_valid_next = out_load | (out_valid_reg & ~m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            deadline_reg  <= cbm_pkg::DEADLINE_RST;
            peak_reg      <= '0;
            least_reg     <= '1;
            avg_reg       <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            overrun_reg   <= '0;
            xrun_reg      <= '0;
            elapsed_reg   <= '0;
            load_reg      <= '0;
            on_time_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            deadline_reg  <= deadline_next;
            peak_reg      <= peak_next;
            least_reg     <= least_next;
            avg_reg       <= avg_next;
            total_reg     <= total_next;
            count_reg     <= count_next;
            overrun_reg   <= overrun_next;
            xrun_reg      <= xrun_next;
            elapsed_reg   <= elapsed_next;
            load_reg      <= load_next;
            on_time_reg   <= on_time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // one word in flight: no second accept straight after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a word is in flight");

    // divider only finishes while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside the divide step");

    // divider is only started when it is free
    a_div_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.go |-> !div_stat.busy)
        else $error("divider started while busy");

    // once something is measured the least never exceeds the peak
    a_least_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (least_reg <= peak_reg))
        else $error("least above peak");

    // load stays within saturation
    a_load_sat: assert property (@(posedge clk) disable iff (!rst_n)
        load_reg <= cbm_pkg::LOAD_SAT)
        else $error("load above saturation");
`endif

endmodule
